FILE: rtl/core/tfqe_pkg.sv
// ----------------------------------------------------------------------------
// tfqe_pkg
// Shared types, widths and helpers for the tangent frame quaternion encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfqe_pkg;

  localparam int FRAC_BITS = 15;
  localparam int QMAX      = (1 << FRAC_BITS) - 1;

  localparam int E_W     = FRAC_BITS + 3;       // off-diagonal sums, signed
  localparam int MAG_W   = FRAC_BITS + 2;       // |e|
  localparam int ROOT_W  = FRAC_BITS + 2;       // k
  localparam int RAD_W   = 2 * ROOT_W;          // sqrt radicand
  localparam int DEN_W   = ROOT_W + 2;          // 4k
  localparam int QUO_W   = ROOT_W + 1;          // quotient bits
  localparam int NUM_W   = DEN_W + QUO_W - 3;   // rounded numerator

  typedef enum logic [1:0] {
    BIG_X = 2'd0,
    BIG_Y = 2'd1,
    BIG_Z = 2'd2,
    BIG_W = 2'd3
  } big_t;

  typedef struct packed {
    logic signed [15:0] t_x;
    logic signed [15:0] t_y;
    logic signed [15:0] t_z;
    logic signed [15:0] b_x;
    logic signed [15:0] b_y;
    logic signed [15:0] b_z;
    logic signed [15:0] n_x;
    logic signed [15:0] n_y;
    logic signed [15:0] n_z;
  } req_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } rsp_t;

  // travels alongside the square root
  typedef struct packed {
    logic                      refl;
    big_t                      big;
    logic [3:0][E_W-1:0]       e;      // x, y, z, w numerators (two's complement)
  } side_t;

  // travels alongside the dividers
  typedef struct packed {
    logic                      refl;
    big_t                      big;
    logic [3:0]                e_neg;
    logic                      small_w;
    logic                      ew_pos;
    logic [ROOT_W-1:0]         khalf;
    logic [DEN_W-1:0]          den;
  } dside_t;

  // signed component, saturated to +-QMAX
  function automatic logic signed [15:0] sat_q(input logic signed [QUO_W:0] v);
    logic signed [QUO_W:0] hi;
    logic signed [QUO_W:0] lo;
    hi = (QUO_W+1)'(QMAX);
    lo = -(QUO_W+1)'(QMAX);
    if (v > hi) begin
      sat_q = 16'(QMAX);
    end else if (v < lo) begin
      sat_q = -16'(QMAX);
    end else begin
      sat_q = 16'(v);
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tfqe_isqrt.sv
// ----------------------------------------------------------------------------
// tfqe_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tfqe_isqrt
  import tfqe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              adv,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire side_t             in_side,
  output logic                   out_valid,
  output logic [ROOT_W-1:0]      out_root,
  output side_t                  out_side
);

  localparam int REM_W = ROOT_W + 3;

  logic              vld  [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  side_t             side [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_st
    logic              pv;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    logic [RAD_W-1:0]  prad;
    side_t             pside;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prem  = '0;
      assign proot = '0;
      assign prad  = in_rad;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[i-1];
      assign prem  = rem[i-1];
      assign proot = root[i-1];
      assign prad  = rad[i-1];
      assign pside = side[i-1];
    end

    assign cur   = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
    assign trial = {1'b0, proot, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cur >= trial) begin
          rem[i]  <= cur - trial;
          root[i] <= {proot[ROOT_W-2:0], 1'b1};
        end else begin
          rem[i]  <= cur;
          root[i] <= {proot[ROOT_W-2:0], 1'b0};
        end
        rad[i]  <= {prad[RAD_W-3:0], 2'b00};
        side[i] <= pside;
      end
    end
  end

  assign out_valid = vld[ROOT_W-1];
  assign out_root  = root[ROOT_W-1];
  assign out_side  = side[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/tfqe_div.sv
// ----------------------------------------------------------------------------
// tfqe_div
// Four-lane pipelined restoring divider with a shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module tfqe_div
  import tfqe_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  adv,
  input  wire logic                  in_valid,
  input  wire logic [3:0][NUM_W-1:0] in_num,
  input  wire dside_t                in_side,
  output logic                       out_valid,
  output logic [3:0][QUO_W-1:0]      out_quo,
  output dside_t                     out_side
);

  logic                    vld  [QUO_W];
  logic [3:0][DEN_W-1:0]   rem  [QUO_W];
  logic [3:0][QUO_W-1:0]   low  [QUO_W];
  logic [3:0][QUO_W-1:0]   quo  [QUO_W];
  dside_t                  side [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_st
    logic                  pv;
    logic [3:0][DEN_W-1:0] prem;
    logic [3:0][QUO_W-1:0] plow;
    logic [3:0][QUO_W-1:0] pquo;
    dside_t                pside;

    if (i == 0) begin : g_first
      assign pv = in_valid;
      for (genvar l = 0; l < 4; l++) begin : g_ld
        assign prem[l] = DEN_W'(in_num[l][NUM_W-1:QUO_W]);
        assign plow[l] = in_num[l][QUO_W-1:0];
      end
      assign pquo  = '0;
      assign pside = in_side;
    end else begin : g_next
      assign pv    = vld[i-1];
      assign prem  = rem[i-1];
      assign plow  = low[i-1];
      assign pquo  = quo[i-1];
      assign pside = side[i-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= pv;
      end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic [DEN_W:0] cur;
      assign cur = {prem[l], plow[l][QUO_W-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          if (cur >= {1'b0, pside.den}) begin
            rem[i][l] <= DEN_W'(cur - {1'b0, pside.den});
            quo[i][l] <= {pquo[l][QUO_W-2:0], 1'b1};
          end else begin
            rem[i][l] <= DEN_W'(cur);
            quo[i][l] <= {pquo[l][QUO_W-2:0], 1'b0};
          end
          low[i][l] <= {plow[l][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        side[i] <= pside;
      end
    end
  end

  assign out_valid = vld[QUO_W-1];
  assign out_quo   = quo[QUO_W-1];
  assign out_side  = side[QUO_W-1];

endmodule

`default_nettype wire

FILE: rtl/core/tangent_frame_quaternion_encoder.sv
// ----------------------------------------------------------------------------
// tangent_frame_quaternion_encoder
// Packs a Q1.15 tangent frame into a 16-bit QTangent quaternion.
// ----------------------------------------------------------------------------
// Use:
//   Request channel req/req_valid/req_stall carries one frame (t, b, n
//   columns). Response channel rsp/rsp_valid/rsp_stall returns quat x,y,z,w.
//   A request is taken on any edge with valid high and stall low.
// Pipeline: 4 determinant/setup stages, 17 square-root stages,
//   1 numerator stage, 18 divider stages, 1 output.
// Throughput: one request per cycle unless stalled; the radicand root
//   and four quotients are one bit per stage, so every stage is independent.
// Stall: the whole pipe advances together. When the output register is
//   full and rsp_stall is high, all stages hold and req_stall is raised;
//   nothing is dropped or duplicated.
// Reset: clears every stage valid bit and the output valid; payload
//   registers are left as they are.
// ----------------------------------------------------------------------------
`default_nettype none

module tangent_frame_quaternion_encoder
  import tfqe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_stall,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_stall,
  output rsp_t      rsp
);

  localparam int ONE = 1 << FRAC_BITS;

  logic adv;
  assign adv       = !rsp_valid || !rsp_stall;
  assign req_stall = !adv;

  // stage 1: cofactor products
  logic               v1;
  req_t               m1;
  logic signed [31:0] pa, pb, pc, pd, pe, pf;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1 <= req;
      pa <= req.b_y * req.n_z;
      pb <= req.n_y * req.b_z;
      pc <= req.t_y * req.n_z;
      pd <= req.n_y * req.t_z;
      pe <= req.t_y * req.b_z;
      pf <= req.b_y * req.t_z;
    end
  end

  // stage 2: minors times first row
  logic               v2;
  req_t               m2;
  logic signed [48:0] d0, d1, d2;
  logic signed [32:0] c0, c1, c2;

  assign c0 = 33'(pa) - 33'(pb);
  assign c1 = 33'(pc) - 33'(pd);
  assign c2 = 33'(pe) - 33'(pf);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2 <= m1;
      d0 <= 49'(m1.t_x) * 49'(c0);
      d1 <= 49'(m1.b_x) * 49'(c1);
      d2 <= 49'(m1.n_x) * 49'(c2);
    end
  end

  // stage 3: determinant sign
  logic               v3;
  req_t               m3;
  logic               refl3;
  logic signed [50:0] det;

  assign det = 51'(d0) - 51'(d1) + 51'(d2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3    <= m2;
      refl3 <= det[50] || (det == '0);
    end
  end

  // stage 4: flip normal, pick largest diagonal term, numerators
  logic signed [16:0] nx, ny, nz;
  logic signed [18:0] fx, fy, fz, fw, best;
  big_t               big;
  logic [17:0]        best_u;
  logic [RAD_W-1:0]   rad;
  side_t              side4;
  logic               v4;
  logic [RAD_W-1:0]   rad4;
  side_t              side4_r;

  always_comb begin
    nx = refl3 ? -17'(m3.n_x) : 17'(m3.n_x);
    ny = refl3 ? -17'(m3.n_y) : 17'(m3.n_y);
    nz = refl3 ? -17'(m3.n_z) : 17'(m3.n_z);
    fx = 19'(m3.t_x) - 19'(m3.b_y) - 19'(nz);
    fy = 19'(m3.b_y) - 19'(m3.t_x) - 19'(nz);
    fz = 19'(nz) - 19'(m3.t_x) - 19'(m3.b_y);
    fw = 19'(m3.t_x) + 19'(m3.b_y) + 19'(nz);
    big  = BIG_W;
    best = fw;
    if (fx > best) begin
      best = fx;
      big  = BIG_X;
    end
    if (fy > best) begin
      best = fy;
      big  = BIG_Y;
    end
    if (fz > best) begin
      best = fz;
      big  = BIG_Z;
    end
    best_u = best[18] ? '0 : 18'(best);
    rad    = RAD_W'(best_u + 18'(ONE)) << FRAC_BITS;

    side4.refl = refl3;
    side4.big  = big;
    case (big)
      BIG_X: begin
        side4.e[0] = '0;
        side4.e[1] = E_W'(m3.t_y) + E_W'(m3.b_x);
        side4.e[2] = E_W'(nx) + E_W'(m3.t_z);
        side4.e[3] = E_W'(m3.b_z) - E_W'(ny);
      end
      BIG_Y: begin
        side4.e[0] = E_W'(m3.t_y) + E_W'(m3.b_x);
        side4.e[1] = '0;
        side4.e[2] = E_W'(m3.b_z) + E_W'(ny);
        side4.e[3] = E_W'(nx) - E_W'(m3.t_z);
      end
      BIG_Z: begin
        side4.e[0] = E_W'(nx) + E_W'(m3.t_z);
        side4.e[1] = E_W'(m3.b_z) + E_W'(ny);
        side4.e[2] = '0;
        side4.e[3] = E_W'(m3.t_y) - E_W'(m3.b_x);
      end
      default: begin
        side4.e[0] = E_W'(m3.b_z) - E_W'(ny);
        side4.e[1] = E_W'(nx) - E_W'(m3.t_z);
        side4.e[2] = E_W'(m3.t_y) - E_W'(m3.b_x);
        side4.e[3] = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rad4    <= rad;
      side4_r <= side4;
    end
  end

  // k = floor(sqrt((D + 1) * 2^F))
  logic              sq_valid;
  logic [ROOT_W-1:0] k;
  side_t             sq_side;

  tfqe_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v4),
    .in_rad    (rad4),
    .in_side   (side4_r),
    .out_valid (sq_valid),
    .out_root  (k),
    .out_side  (sq_side)
  );

  // numerator stage: round-to-nearest numerators |e|*2^(F+1) + 2k over 4k
  logic [3:0][MAG_W-1:0] mag;
  logic [3:0][NUM_W-1:0] num;
  dside_t                ds;
  logic                  vp;
  logic [3:0][NUM_W-1:0] num_r;
  dside_t                ds_r;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      mag[l] = sq_side.e[l][E_W-1] ? MAG_W'(-sq_side.e[l]) : MAG_W'(sq_side.e[l]);
      num[l] = NUM_W'({mag[l], (FRAC_BITS + 1)'(0)}) + NUM_W'({k, 1'b0});
      ds.e_neg[l] = sq_side.e[l][E_W-1];
    end
    ds.refl    = sq_side.refl;
    ds.big     = sq_side.big;
    ds.ew_pos  = !sq_side.e[3][E_W-1] && (sq_side.e[3] != '0);
    // |w| below one LSB when w is not the root term
    ds.small_w = (sq_side.big != BIG_W) &&
                 ((MAG_W + FRAC_BITS)'({mag[3], FRAC_BITS'(0)}) <
                  (MAG_W + FRAC_BITS)'({k, 1'b0}));
    ds.khalf   = ROOT_W'((ROOT_W + 1)'(k) + (ROOT_W + 1)'(1) >> 1);
    ds.den     = {k, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      num_r <= num;
      ds_r  <= ds;
    end
  end

  logic                  dv_valid;
  logic [3:0][QUO_W-1:0] quo;
  dside_t                dv_side;

  tfqe_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (vp),
    .in_num    (num_r),
    .in_side   (ds_r),
    .out_valid (dv_valid),
    .out_quo   (quo),
    .out_side  (dv_side)
  );

  // sign, root term, small w, saturation, reflection encoding
  logic signed [3:0][15:0] qs;
  logic                    flip;
  rsp_t                    rsp_next;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (dv_side.big == big_t'(2'(l))) begin
        qs[l] = sat_q((QUO_W + 1)'(dv_side.khalf));
      end else if (dv_side.e_neg[l]) begin
        qs[l] = sat_q(-(QUO_W + 1)'(quo[l]));
      end else begin
        qs[l] = sat_q((QUO_W + 1)'(quo[l]));
      end
    end
    if (dv_side.small_w) begin
      qs[3] = dv_side.ew_pos ? 16'sd1 : -16'sd1;
    end
    flip = (dv_side.refl && !qs[3][15] && (qs[3] != '0)) ||
           (!dv_side.refl && qs[3][15]);
    rsp_next.quat_x = flip ? -qs[0] : qs[0];
    rsp_next.quat_y = flip ? -qs[1] : qs[1];
    rsp_next.quat_z = flip ? -qs[2] : qs[2];
    rsp_next.quat_w = flip ? -qs[3] : qs[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (adv) begin
      rsp_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
